[design/chtb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chtb_pkg;

	localparam int IDX_W  = 9;
	localparam int LEN_W  = 4;
	localparam int CODE_W = 16;
	localparam int LINK_W = 10;
	localparam int CFG_W  = 9;
	localparam int STS_W  = 2;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [STS_W-1:0] ST_OK  = 2'd0;
	localparam logic [STS_W-1:0] ST_BAD = 2'd1;
	localparam logic [STS_W-1:0] ST_OVF = 2'd2;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 9'd256;

	typedef struct packed {
		logic idle;
		logic clr;
		logic build_init;
		logic lclr;
		logic h_add;
		logic nc;
		logic a_wr;
		logic t_chk;
		logic n_ev;
		logic fin;
	} chtb_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic lclr_last;
		logic sym_last;
		logic nc_last;
		logic len_zero;
		logic j_zero;
		logic slot_empty;
		logic pool_full;
	} chtb_sts_t;

endpackage

`default_nettype wire

[design/chtb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module chtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

[design/chtb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module chtb_ctrl
	import chtb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  wire chtb_sts_t  sts,
	output chtb_cmd_t       cmd,
	output logic            busy
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LCLR = 4'd2;
	localparam logic [3:0] S_HRD  = 4'd3;
	localparam logic [3:0] S_HADD = 4'd4;
	localparam logic [3:0] S_NC   = 4'd5;
	localparam logic [3:0] S_ARD  = 4'd6;
	localparam logic [3:0] S_AWR  = 4'd7;
	localparam logic [3:0] S_TRD  = 4'd8;
	localparam logic [3:0] S_TCHK = 4'd9;
	localparam logic [3:0] S_NRD  = 4'd10;
	localparam logic [3:0] S_NEV  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (start && req_type == REQ_BUILD) begin
					cmd.build_init = 1'b1;
					state_d        = S_LCLR;
				end
			end
			S_LCLR: begin
				cmd.lclr = 1'b1;
				if (sts.lclr_last) state_d = S_HRD;
			end
			S_HRD: state_d = S_HADD;
			S_HADD: begin
				cmd.h_add = 1'b1;
				state_d   = sts.sym_last ? S_NC : S_HRD;
			end
			S_NC: begin
				cmd.nc = 1'b1;
				if (sts.nc_last) state_d = S_ARD;
			end
			S_ARD: state_d = S_AWR;
			S_AWR: begin
				cmd.a_wr = 1'b1;
				state_d  = sts.sym_last ? S_TRD : S_ARD;
			end
			S_TRD: state_d = S_TCHK;
			S_TCHK: begin
				cmd.t_chk = 1'b1;
				if (!sts.len_zero) state_d = S_NRD;
				else state_d = sts.sym_last ? S_FIN : S_TRD;
			end
			S_NRD: state_d = S_NEV;
			S_NEV: begin
				cmd.n_ev = 1'b1;
				if (sts.j_zero) begin
					if (!sts.slot_empty || sts.sym_last) state_d = S_FIN;
					else state_d = S_TRD;
				end else if (sts.slot_empty && sts.pool_full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_NRD;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[design/chtb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module chtb_dp
	import chtb_pkg::*;
#(
	parameter int MAX_SYMBOLS = 256,
	parameter int MAX_LENGTH  = 15
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire chtb_cmd_t                cmd,
	output chtb_sts_t                     sts,
	input  wire logic                     start,
	input  wire logic [1:0]               req_type,
	input  wire logic [IDX_W-1:0]         node_index,
	input  wire logic [LEN_W-1:0]         length_in,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	output logic                          done,
	output logic [STS_W-1:0]              status,
	output logic [CODE_W-1:0]             code_out,
	output logic [LEN_W-1:0]              length_out,
	output logic signed [LINK_W-1:0]      zero_link,
	output logic signed [LINK_W-1:0]      one_link
);

	localparam int SW = $clog2(MAX_SYMBOLS);
	localparam int NW = $clog2(MAX_SYMBOLS + 1);
	localparam int ND = 2 * MAX_SYMBOLS;
	localparam int AW = $clog2(ND);
	localparam int LW = $clog2(MAX_LENGTH + 1);

	logic [CFG_W-1:0]  act_q;
	logic [SW-1:0]     i_q;
	logic [AW-1:0]     k_q, free_q;
	logic [LEN_W-1:0]  j_q;
	logic [LW-1:0]     c_q;
	logic [CODE_W-1:0] value_q, code_q;
	logic [CODE_W-1:0] hist_q [MAX_LENGTH+1];
	logic [CODE_W-1:0] nxt_q  [MAX_LENGTH+1];
	logic [STS_W-1:0]  status_q;
	logic              done_q, rd_q, rd_sym_q, rd_node_q;

	logic [NW-1:0]       n;
	logic [NW:0]         two_n;
	logic [AW-1:0]       root;
	logic                accept;
	logic [LEN_W-1:0]    len_rd, len_sat;
	logic [LW-1:0]       len_idx;
	logic [CODE_W-1:0]   code_rd, sum, value_next, hist_prev;
	logic [2*LINK_W-1:0] lk_rd, lk_wd;
	logic [LINK_W-1:0]   slot, newv;
	logic                bit_sel;
	logic                len_we, code_we, lk_we;
	logic [SW-1:0]       sym_addr;
	logic [AW-1:0]       node_addr;

	always_comb begin
		if (act_q == '0) n = NW'(1);
		else if (10'(act_q) > 10'(MAX_SYMBOLS)) n = NW'(MAX_SYMBOLS);
		else n = NW'(act_q);
	end
	assign two_n = {n, 1'b0};
	assign root  = AW'(two_n - (NW+1)'(1));

	assign accept  = start && cmd.idle;
	assign len_sat = (length_in > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : length_in;
	assign len_idx = len_rd[LW-1:0];

	assign sym_addr  = cmd.idle ? SW'(node_index) : i_q;
	assign node_addr = cmd.idle ? AW'(node_index) : k_q;

	assign len_we  = cmd.clr || (accept && req_type == REQ_WRITE
		&& 10'(node_index) < 10'(MAX_SYMBOLS));
	assign code_we = cmd.clr || (cmd.a_wr && !sts.len_zero);

	// code bit for this tree level picks the child slot
	assign bit_sel = code_q[j_q];
	assign slot    = bit_sel ? lk_rd[2*LINK_W-1:LINK_W] : lk_rd[LINK_W-1:0];
	assign newv    = sts.j_zero ? LINK_W'(i_q) : LINK_W'(free_q);
	assign lk_we   = cmd.lclr
		|| (cmd.n_ev && sts.slot_empty && (sts.j_zero || !sts.pool_full));
	always_comb begin
		if (cmd.lclr) lk_wd = '1;
		else if (bit_sel) lk_wd = {newv, lk_rd[LINK_W-1:0]};
		else lk_wd = {lk_rd[2*LINK_W-1:LINK_W], newv};
	end

	assign hist_prev  = (c_q == LW'(1)) ? '0 : hist_q[c_q - LW'(1)];
	assign sum        = value_q + hist_prev;
	assign value_next = {sum[CODE_W-2:0], 1'b0};

	chtb_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SYMBOLS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.addr  (sym_addr),
		.wdata (cmd.clr ? '0 : len_sat),
		.rdata (len_rd)
	);

	chtb_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SYMBOLS)) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.addr  (sym_addr),
		.wdata (cmd.clr ? '0 : nxt_q[len_idx]),
		.rdata (code_rd)
	);

	chtb_ram #(.WIDTH(2*LINK_W), .DEPTH(ND)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.addr  (node_addr),
		.wdata (lk_wd),
		.rdata (lk_rd)
	);

	always_comb begin
		sts.clr_last   = (i_q == SW'(MAX_SYMBOLS - 1));
		sts.lclr_last  = (k_q == root);
		sts.sym_last   = (NW'(i_q) == n - NW'(1));
		sts.nc_last    = (c_q == LW'(MAX_LENGTH));
		sts.len_zero   = (len_rd == '0);
		sts.j_zero     = (j_q == '0);
		sts.slot_empty = (slot == '1);
		sts.pool_full  = (free_q == root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= ACTIVE_RESET;
			i_q       <= '0;
			k_q       <= '0;
			free_q    <= '0;
			status_q  <= ST_OK;
			done_q    <= 1'b0;
			rd_q      <= 1'b0;
			rd_sym_q  <= 1'b0;
			rd_node_q <= 1'b0;
		end else begin
			if (cfg_we) act_q <= cfg_wdata;
			// a build answers only when it finishes
			done_q <= (accept && req_type != REQ_BUILD) || cmd.fin;
			if (accept) begin
				rd_q      <= (req_type == REQ_READ);
				rd_sym_q  <= 11'(node_index) < 11'(n);
				rd_node_q <= 11'(node_index) < 11'(two_n);
				status_q  <= ST_OK;
			end
			if (cmd.fin) rd_q <= 1'b0;
			if (cmd.clr) i_q <= sts.clr_last ? '0 : i_q + SW'(1);
			if (cmd.build_init) k_q <= '0;
			if (cmd.lclr) begin
				k_q <= k_q + AW'(1);
				if (sts.lclr_last) i_q <= '0;
			end
			if (cmd.h_add) i_q <= sts.sym_last ? '0 : i_q + SW'(1);
			if (cmd.a_wr) begin
				i_q <= sts.sym_last ? '0 : i_q + SW'(1);
				if (sts.sym_last) free_q <= AW'(n);
			end
			if (cmd.t_chk) begin
				k_q <= root;
				if (sts.len_zero && !sts.sym_last) i_q <= i_q + SW'(1);
			end
			if (cmd.n_ev) begin
				if (sts.j_zero) begin
					if (!sts.slot_empty) status_q <= ST_BAD;
					else if (!sts.sym_last) i_q <= i_q + SW'(1);
				end else if (sts.slot_empty) begin
					if (sts.pool_full) begin
						status_q <= ST_OVF;
					end else begin
						k_q    <= free_q;
						free_q <= free_q + AW'(1);
					end
				end else begin
					k_q <= AW'(slot);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build_init) begin
			for (int h = 0; h <= MAX_LENGTH; h++) hist_q[h] <= '0;
		end
		if (cmd.h_add) begin
			hist_q[len_idx] <= hist_q[len_idx] + CODE_W'(1);
			c_q             <= LW'(1);
			value_q         <= '0;
		end
		if (cmd.nc) begin
			value_q    <= value_next;
			nxt_q[c_q] <= value_next;
			c_q        <= c_q + LW'(1);
		end
		if (cmd.a_wr && !sts.len_zero) nxt_q[len_idx] <= nxt_q[len_idx] + CODE_W'(1);
		if (cmd.t_chk) begin
			code_q <= code_rd;
			j_q    <= len_rd - LEN_W'(1);
		end
		if (cmd.n_ev) j_q <= j_q - LEN_W'(1);
	end

	assign done       = done_q;
	assign status     = status_q;
	assign code_out   = (rd_q && rd_sym_q) ? code_rd : '0;
	assign length_out = (rd_q && rd_sym_q) ? len_rd : '0;
	assign zero_link  = (rd_q && rd_node_q) ? lk_rd[LINK_W-1:0] : '1;
	assign one_link   = (rd_q && rd_node_q) ? lk_rd[2*LINK_W-1:LINK_W] : '1;

endmodule

`default_nettype wire

[design/canonical_huffman_tree_builder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Canonical Huffman code assignment and decode tree builder.
// Requests: pulse start with req_type, node_index and length_in; a request is
// taken when start is high and busy is low. cfg_we/cfg_wdata write the
// alphabet size; the user must do so only while the block is idle; unchecked.
// Length writes and node reads are taken one per cycle while idle; each
// answers on the next cycle with done high for exactly one cycle (status,
// code_out, length_out, zero_link, one_link). The receiver cannot stall: a
// result not taken in its done cycle is gone.
// A build holds busy through link clear, histogram, first codes, code
// assignment, the tree walks of the symbols and finish, since the length,
// code and link memories are single ported with a registered read; done
// is high in the first cycle busy is low.
// After reset the length and code memories are cleared, one entry a cycle,
// with busy high until every entry is clear; alphabet size resets to 256.
// Links read before the first build are undefined.
module canonical_huffman_tree_builder_top
	import chtb_pkg::*;
#(
	parameter int MAX_SYMBOLS = 256,
	parameter int MAX_LENGTH  = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          req_type,
	input  wire logic [IDX_W-1:0]    node_index,
	input  wire logic [LEN_W-1:0]    length_in,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	output logic                     done,
	output logic [STS_W-1:0]         status,
	output logic [CODE_W-1:0]        code_out,
	output logic [LEN_W-1:0]         length_out,
	output logic signed [LINK_W-1:0] zero_link,
	output logic signed [LINK_W-1:0] one_link
);

	chtb_cmd_t cmd;
	chtb_sts_t sts;

	chtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	chtb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_LENGTH(MAX_LENGTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.start      (start),
		.req_type   (req_type),
		.node_index (node_index),
		.length_in  (length_in),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.status     (status),
		.code_out   (code_out),
		.length_out (length_out),
		.zero_link  (zero_link),
		.one_link   (one_link)
	);

`ifndef NO_ASSERTIONS
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_BUILD) |=> (done && !busy))
		else $error("write/read transfer not answered next cycle");
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_BUILD) |=> (busy && !done))
		else $error("build did not hold busy");
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (code_out == '0 && length_out == '0))
		else $error("failed build result carries read data");
`endif

endmodule

`default_nettype wire

[sim/tb_canonical_huffman_tree_builder_top.sv]
`timescale 1ns / 1ps

module tb_canonical_huffman_tree_builder_top;
	import chtb_pkg::*;

	localparam int SYMS = 256;
	localparam int MAXLEN = 15;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int NO_LINK = -1;
	localparam int LIMIT = 3000000;

	typedef struct {
		bit is_cfg;
		logic [CFG_W-1:0] cfg;
		logic [1:0] req;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
	} req_item_t;

	typedef struct {
		logic [STS_W-1:0] sts;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0] len;
		logic [LINK_W-1:0] zl;
		logic [LINK_W-1:0] ol;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] req_type = REQ_WRITE;
	logic [IDX_W-1:0] node_index = '0;
	logic [LEN_W-1:0] length_in = '0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic busy, done;
	logic [STS_W-1:0] status;
	logic [CODE_W-1:0] code_out;
	logic [LEN_W-1:0] length_out;
	logic signed [LINK_W-1:0] zero_link, one_link;

	canonical_huffman_tree_builder_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .node_index(node_index), .length_in(length_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .status(status),
		.code_out(code_out), .length_out(length_out),
		.zero_link(zero_link), .one_link(one_link)
	);

	always #1 clk = ~clk;

	// shadow of the block
	logic [CFG_W-1:0] alpha_size = ACTIVE_RESET;
	int lens[SYMS];
	int codes[SYMS];
	int zlinks[2*SYMS];
	int olinks[2*SYMS];

	req_item_t pending[$];
	answer_t answers[$];
	req_item_t cur;
	int gap = 0, quiet = 0, mismatches = 0, n_items = 0, n_builds = 0, n_bad = 0;
	int n_ovf = 0, n_checked = 0, cycles = 0;

	function automatic int eff_n();
		int n = alpha_size;
		if (n < 1) n = 1;
		if (n > SYMS) n = SYMS;
		return n;
	endfunction

	function automatic int build_codes_and_tree(int n);
		int hist[MAXLEN+1];
		int first[MAXLEN+1];
		int value, k, slot, free_n, last, b, st;
		value = 0;
		st = ST_OK;
		for (int l = 0; l <= MAXLEN; l++) hist[l] = 0;
		for (int i = 0; i < n; i++) hist[lens[i]]++;
		hist[0] = 0;
		first[0] = 0;
		for (int l = 1; l <= MAXLEN; l++) begin
			value = ((value + hist[l-1]) << 1) & 16'hFFFF;
			first[l] = value;
		end
		for (int i = 0; i < n; i++) begin
			if (lens[i] != 0) begin
				codes[i] = first[lens[i]];
				first[lens[i]] = (first[lens[i]] + 1) & 16'hFFFF;
			end
		end
		for (int i = 0; i < 2*n; i++) begin
			zlinks[i] = NO_LINK;
			olinks[i] = NO_LINK;
		end
		free_n = n;
		last = 2*n - 1;
		for (int i = 0; i < n && st == ST_OK; i++) begin
			k = last;
			for (int j = lens[i] - 1; j >= 0 && st == ST_OK; j--) begin
				b = (codes[i] >> j) & 1;
				slot = b ? olinks[k] : zlinks[k];
				if (j == 0) begin
					if (slot != NO_LINK) st = ST_BAD;
					else if (b) olinks[k] = i;
					else zlinks[k] = i;
				end else begin
					if (slot == NO_LINK) begin
						if (free_n == last) st = ST_OVF;
						else begin
							slot = free_n;
							if (b) olinks[k] = slot;
							else zlinks[k] = slot;
							free_n++;
						end
					end
					k = slot;
				end
			end
		end
		return st;
	endfunction

	function automatic answer_t predict_answer(req_item_t it);
		answer_t a;
		int n = eff_n();
		int l;
		a.sts = ST_OK;
		a.code = '0;
		a.len = '0;
		a.zl = LINK_W'(NO_LINK);
		a.ol = LINK_W'(NO_LINK);
		if (it.req == REQ_WRITE) begin
			l = it.len;
			if (l > MAXLEN) l = MAXLEN;
			if (it.idx < SYMS) lens[it.idx] = l;
		end else if (it.req == REQ_BUILD) begin
			a.sts = STS_W'(build_codes_and_tree(n));
		end else if (it.req == REQ_READ && it.idx < 2*n) begin
			if (it.idx < n) begin
				a.code = CODE_W'(codes[it.idx]);
				a.len = LEN_W'(lens[it.idx]);
			end
			a.zl = LINK_W'(zlinks[it.idx]);
			a.ol = LINK_W'(olinks[it.idx]);
		end
		return a;
	endfunction

	// driver
	always @(posedge clk) begin
		logic nxt_start, nxt_we;
		answer_t a;
		if (arst_n) begin
			nxt_start = start;
			nxt_we = 1'b0;
			if (start && !busy) begin
				a = predict_answer(cur);
				answers.push_back(a);
				if (cur.req == REQ_BUILD) begin
					n_builds++;
					if (a.sts == ST_BAD) n_bad++;
					if (a.sts == ST_OVF) n_ovf++;
				end
				nxt_start = 1'b0;
			end
			if (gap > 0) begin
				gap--;
			end else if (!nxt_start && pending.size() > 0) begin
				if (pending[0].is_cfg) begin
					if (answers.size() == 0 && quiet >= 12 && !busy && !start) begin
						alpha_size = pending[0].cfg;
						cfg_wdata <= pending[0].cfg;
						nxt_we = 1'b1;
						void'(pending.pop_front());
					end
				end else begin
					cur = pending.pop_front();
					req_type <= cur.req;
					node_index <= cur.idx;
					length_in <= cur.len;
					nxt_start = 1'b1;
					if (pending.size() > 200 && $urandom_range(0, 4) == 0)
						gap = $urandom_range(1, 18);
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
			if (answers.size() == 0 && !start && !done) quiet++;
			else quiet = 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
			end else begin
				e = answers.pop_front();
				n_checked++;
				if (status !== e.sts || code_out !== e.code || length_out !== e.len ||
				    zero_link !== e.zl || one_link !== e.ol) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp sts %0d code %h len %0d links %0d/%0d,",
							" got sts %0d code %h len %0d links %0d/%0d"},
							e.sts, e.code, e.len, $signed(e.zl), $signed(e.ol),
							status, code_out, length_out, zero_link, one_link);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus generation
	int gen_n = SYMS;
	int span = 0;

	task automatic push_cfg(int v);
		req_item_t it;
		it.is_cfg = 1'b1;
		it.cfg = CFG_W'(v);
		it.req = REQ_WRITE;
		it.idx = '0;
		it.len = '0;
		pending.push_back(it);
		gen_n = (v < 1) ? 1 : (v > SYMS ? SYMS : v);
	endtask

	task automatic push_req(logic [1:0] r, int idx, int l);
		req_item_t it;
		it.is_cfg = 1'b0;
		it.cfg = '0;
		it.req = r;
		it.idx = IDX_W'(idx);
		it.len = LEN_W'(l);
		// links of nodes never cleared by a build are undefined
		if (r == REQ_READ && idx < 2*gen_n && idx >= span) it.idx = IDX_W'(2*gen_n);
		if (r == REQ_BUILD && 2*gen_n > span) span = 2*gen_n;
		pending.push_back(it);
		n_items++;
	endtask

	task automatic push_reads(int cnt);
		int hi;
		hi = 2*gen_n + 3;
		if (hi > 511) hi = 511;
		for (int r = 0; r < cnt; r++) begin
			if ($urandom_range(0, 7) == 0) push_req(REQ_READ, $urandom_range(0, 511), 0);
			else push_req(REQ_READ, $urandom_range(0, hi), 0);
		end
	endtask

	// complete prefix code from a two leaf root or one lone code, random symbols
	task automatic push_tree_round();
		int q[$];
		int perm[SYMS];
		int assigned[SYMS];
		int k, p, tries, tmp, sw;
		k = $urandom_range(1, (gen_n < 40) ? gen_n : 40);
		if (k == 1) q.push_back($urandom_range(1, MAXLEN));
		else begin
			q.push_back(1);
			q.push_back(1);
		end
		tries = 0;
		while (q.size() < k && tries < 200) begin
			p = $urandom_range(0, q.size() - 1);
			if (q[p] < MAXLEN) begin
				q[p] = q[p] + 1;
				q.push_back(q[p]);
			end
			tries++;
		end
		for (int i = 0; i < gen_n; i++) begin
			perm[i] = i;
			assigned[i] = 0;
		end
		for (int i = gen_n - 1; i > 0; i--) begin
			sw = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[sw];
			perm[sw] = tmp;
		end
		for (int t = 0; t < q.size() && t < gen_n; t++) assigned[perm[t]] = q[t];
		if ($urandom_range(0, 4) == 0)
			assigned[$urandom_range(0, gen_n - 1)] = $urandom_range(0, 15);
		for (int i = 0; i < gen_n; i++) push_req(REQ_WRITE, i, assigned[i]);
		if ($urandom_range(0, 5) == 0)
			push_req(REQ_SPARE, $urandom_range(0, 511), $urandom_range(0, 15));
		if ($urandom_range(0, 5) == 0)
			push_req(REQ_WRITE, $urandom_range(256, 511), $urandom_range(0, 15));
		push_req(REQ_BUILD, $urandom_range(0, 511), $urandom_range(0, 15));
		push_reads($urandom_range(4, 14));
	endtask

	initial begin
		int v;
		int sizes[6] = '{0, 1, 2, 511, 256, 300};
		// directed
		push_cfg(8);
		push_req(REQ_READ, 511, 0);
		push_req(REQ_READ, 16, 15);
		push_req(REQ_WRITE, 0, 15);
		push_req(REQ_WRITE, 511, 3);
		push_req(REQ_WRITE, 255, 1);
		push_req(REQ_SPARE, 511, 15);
		push_req(REQ_BUILD, 0, 0);      // deep single path: pool overflow
		push_req(REQ_READ, 0, 0);
		push_req(REQ_READ, 15, 0);
		push_req(REQ_WRITE, 0, 1);
		push_req(REQ_WRITE, 1, 1);
		push_req(REQ_WRITE, 2, 1);
		push_req(REQ_BUILD, 0, 0);      // three one-bit codes: slot taken
		push_req(REQ_READ, 2, 0);
		push_req(REQ_READ, 15, 0);
		push_req(REQ_WRITE, 2, 3);
		push_req(REQ_WRITE, 3, 3);
		push_req(REQ_BUILD, 0, 0);      // codes past a leaf
		push_req(REQ_READ, 3, 0);
		push_req(REQ_READ, 8, 0);
		push_req(REQ_READ, 14, 0);
		for (int i = 0; i < 4; i++) push_req(REQ_WRITE, i, 0);
		push_req(REQ_BUILD, 0, 0);      // nothing used
		push_req(REQ_READ, 15, 0);
		// sweep alphabet sizes, extremes first
		foreach (sizes[i]) begin
			v = sizes[i];
			push_cfg(v);
			push_tree_round();
			if (gen_n < 64) push_tree_round();
		end
		while (n_items < 1800) begin
			if ($urandom_range(0, 15) == 0) v = $urandom_range(64, 511);
			else v = $urandom_range(0, 24);
			push_cfg(v);
			for (int r = $urandom_range(1, 4); r > 0 && n_items < 1800; r--)
				push_tree_round();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending.size() != 0 || start || answers.size() != 0);
		repeat (20) @(posedge clk);
		$display("%0d requests, %0d results checked; %0d builds (%0d bad structure, %0d overflow)",
			n_items, n_checked, n_builds, n_bad, n_ovf);
		if (mismatches == 0 && answers.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[canonical_huffman_tree_builder_top.f]
design/chtb_pkg.sv
design/chtb_ram.sv
design/chtb_ctrl.sv
design/chtb_dp.sv
design/canonical_huffman_tree_builder_top.sv
sim/tb_canonical_huffman_tree_builder_top.sv
